// ===== rtl/fcss_pkg.sv =====
// shared types, constants and helpers for the floppy sector stream block
`timescale 1ns / 1ps

package fcss_pkg;

   // block configuration
   localparam int DRIVES            = 4;
   localparam int SECTORS_PER_TRACK = 10;
   localparam int WORDS_PER_SECTOR  = 256;

   // fixed sizes
   localparam int IMAGE_WORDS  = 4096;
   localparam int IMG_ADDR_W   = 12;
   localparam int DRV_ADDR_W   = 2;
   localparam int DRV_SLOTS    = 4;
   localparam int IMG_MEM_AW   = DRV_ADDR_W + IMG_ADDR_W;
   localparam int IMG_MEM_DEPTH = DRV_SLOTS * IMAGE_WORDS;
   localparam int POS_W        = 9;
   localparam int SEC_W        = 4;
   localparam int SEL_W        = 3;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_AW      = 2;
   localparam int FIFO_CW      = 3;

   localparam logic [SEL_W-1:0] NO_DRIVE = 3'd4;

   // stream words
   localparam logic [15:0] W_FILL = 16'o047116;
   localparam logic [15:0] W_LAST = 16'o120641;
   localparam logic [15:0] W_IDX  = 16'o120776;
   localparam logic [15:0] W_DATA = 16'o120773;
   localparam logic [15:0] W_END  = 16'o120770;
   localparam logic [15:0] IDLE_RESET = 16'h5555;

   // region lengths and fill counts
   localparam logic [POS_W-1:0] IDX_LEN   = 9'd24;
   localparam logic [POS_W-1:0] IDX_FILL  = 9'd16;
   localparam logic [POS_W-1:0] DATA_LEN  = 9'd19;
   localparam logic [POS_W-1:0] DATA_FILL = 9'd11;
   localparam logic [POS_W-1:0] END_LEN   = 9'd26;
   localparam logic [POS_W-1:0] END_FILL  = 9'd18;
   localparam logic [POS_W-1:0] WPS_LEN   = POS_W'(WORDS_PER_SECTOR);

   // control word bit that starts a transfer
   localparam int START_BIT = 8;

   typedef enum logic [1:0] {
      MODE_CTRL   = 2'd0,
      MODE_STATUS = 2'd1,
      MODE_DATA   = 2'd2,
      MODE_LOAD   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      RGN_INDEX = 2'd0,
      RGN_DMARK = 2'd1,
      RGN_IMAGE = 2'd2,
      RGN_END   = 2'd3
   } region_type;

   // per drive stream state
   typedef struct packed {
      logic             active;
      logic [SEC_W-1:0] sector;
      region_type       region;
      logic [POS_W-1:0] pos;
      logic             pend_trk;
      logic             pend_size;
   } drv_state_type;

   localparam drv_state_type DRV_STATE_RESET = '{
      active:    1'b0,
      sector:    4'd0,
      region:    RGN_INDEX,
      pos:       9'd0,
      pend_trk:  1'b0,
      pend_size: 1'b0
   };

   // one result beat
   typedef struct packed {
      logic [15:0]      read_data;
      logic [SEL_W-1:0] active_drive;
   } rsp_beat_type;

   // word of a marker region at a clamped position
   function automatic logic [15:0] marker_word(input logic [POS_W-1:0] pos,
                                               input logic [POS_W-1:0] fills,
                                               input logic [POS_W-1:0] len,
                                               input logic [15:0] flag);
      logic [15:0] word;
      if (pos < fills) begin
         word = W_FILL;
      end else if (pos + 9'd2 < len) begin
         word = 16'd0;
      end else if (pos + 9'd2 == len) begin
         word = W_LAST;
      end else begin
         word = flag;
      end
      return word;
   endfunction

   // position held below the region length
   function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] pos,
                                                  input logic [POS_W-1:0] len);
      logic [POS_W-1:0] res;
      res = (pos >= len) ? (len - 9'd1) : pos;
      return res;
   endfunction

endpackage

// ===== rtl/fcss_state_mem.sv =====
// per drive stream state memory with valid bits and write-to-read bypass
`timescale 1ns / 1ps

module fcss_state_mem (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [fcss_pkg::DRV_ADDR_W-1:0]  rd_addr,
   output fcss_pkg::drv_state_type          rd_data,
   input  logic                             wr_en,
   input  logic [fcss_pkg::DRV_ADDR_W-1:0]  wr_addr,
   input  fcss_pkg::drv_state_type          wr_data
);
   import fcss_pkg::*;

   drv_state_type              state_mem [DRV_SLOTS];
   logic [DRV_SLOTS-1:0]       valid_ff;
   drv_state_type              rd_data_ff;
   logic                       rd_valid_ff;
   logic                       byp_ff;
   logic                       byp_in;
   drv_state_type              byp_data_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= state_mem[rd_addr];
      end
   end

   // entry valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // bypass when the read meets a write to the same entry
   assign byp_in = rd_en && wr_en && (rd_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byp_in) begin
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      if (byp_ff) begin
         rd_data = byp_data_ff;
      end else if (rd_valid_ff) begin
         rd_data = rd_data_ff;
      end else begin
         rd_data = DRV_STATE_RESET;
      end
   end

endmodule

// ===== rtl/fcss_image_ram.sv =====
// single port disk image memory, one read or write per cycle
`timescale 1ns / 1ps

module fcss_image_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic                            rd_en,
   input  logic [fcss_pkg::IMG_MEM_AW-1:0] addr,
   input  logic [15:0]                     wr_data,
   output logic [15:0]                     rd_data
);
   import fcss_pkg::*;

   logic [15:0] image_mem [IMG_MEM_DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         image_mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= image_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fcss_rsp_fifo.sv =====
// result queue between the pipeline and the result channel
`timescale 1ns / 1ps

module fcss_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  fcss_pkg::rsp_beat_type        push_data,
   input  logic                          pop,
   output fcss_pkg::rsp_beat_type        head_data,
   output logic                          not_empty,
   output logic [fcss_pkg::FIFO_CW-1:0]  count
);
   import fcss_pkg::*;

   rsp_beat_type         slot_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff;
   logic [FIFO_CW-1:0]   count_in;

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_mem[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 3'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   assign head_data = slot_mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

// ===== rtl/floppy_controller_sector_stream.sv =====
// top level of the emulated floppy controller sector stream
`timescale 1ns / 1ps

//  channel | ports                          | direction | beat moves
//  req     | req_valid/req_ready + fields   | in        | one register access
//  rsp     | rsp_valid/rsp_ready + fields   | out       | one result word
//  csr     | csr_wr_en, csr_index, data     | in        | one mask register write
//
// one beat per cycle sustained while the result queue has room
// pipeline: state memory read, state update with image memory access, result queue
// per drive state lives in a four entry memory with bypass for back to back beats
// synchronous reset clears control state; image memory holds garbage until loaded
// req_ready counts queue room against beats in flight, so rsp stalls never drop data

module floppy_controller_sector_stream (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_mode,
   input  logic [1:0]                       req_drive_number,
   input  logic [fcss_pkg::IMG_ADDR_W-1:0]  req_image_address,
   input  logic [15:0]                      req_write_data,
   input  logic                             req_index_pulse,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_read_data,
   output logic [fcss_pkg::SEL_W-1:0]       rsp_active_drive,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [3:0]                       csr_wr_data
);
   import fcss_pkg::*;

   localparam logic CSR_PRESENT  = 1'b0;
   localparam logic CSR_READONLY = 1'b1;

   // configuration registers
   logic [3:0]        present_mask_ff;
   logic [3:0]        readonly_mask_ff;

   // stage 0 signals
   logic              req_fire;
   logic [3:0]        nib;
   logic [SEL_W-1:0]  sel_dec;
   logic [SEL_W-1:0]  sel_new;
   logic [SEL_W-1:0]  sel_ff;
   logic [SEL_W-1:0]  sel_in;
   logic [SEL_W-1:0]  drv_pick;

   // stage 1 registers
   logic                    s1_valid_ff;
   mode_type                s1_mode_ff;
   logic [1:0]              s1_dnum_ff;
   logic [IMG_ADDR_W-1:0]   s1_addr_ff;
   logic [15:0]             s1_wdata_ff;
   logic                    s1_index_ff;
   logic [SEL_W-1:0]        s1_drv_ff;
   logic [SEL_W-1:0]        s1_sel_ff;

   // stage 1 logic
   drv_state_type           st_cur;
   drv_state_type           st_next;
   logic                    st_wr;
   logic                    have;
   logic [DRV_ADDR_W-1:0]   drv_idx;
   logic                    present;
   logic                    readonly;
   logic [15:0]             word;
   logic                    img_rd;
   logic                    img_wr;
   logic [IMG_MEM_AW-1:0]   img_addr;
   logic [POS_W-1:0]        posc;
   logic [POS_W-1:0]        pos_inc;
   logic [12:0]             img_sum;
   logic [SEC_W-1:0]        sector_inc;
   logic [15:0]             idle_ff;
   logic [15:0]             idle_in;
   logic [15:0]             img_rdata;

   // stage 2 registers
   logic                    s2_valid_ff;
   logic                    s2_img_ff;
   logic [15:0]             s2_word_ff;
   logic [SEL_W-1:0]        s2_sel_ff;

   // result queue
   rsp_beat_type            push_beat;
   rsp_beat_type            head_beat;
   logic [FIFO_CW-1:0]      fifo_count;
   logic [FIFO_CW-1:0]      in_flight;
   logic                    rsp_fire;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         present_mask_ff  <= '0;
         readonly_mask_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESENT:  present_mask_ff  <= csr_wr_data;
            CSR_READONLY: readonly_mask_ff <= csr_wr_data;
            default:      present_mask_ff  <= present_mask_ff;
         endcase
      end
   end

   // request handshake with room reserved for every beat in flight
   assign in_flight = fifo_count + FIFO_CW'(s1_valid_ff) + FIFO_CW'(s2_valid_ff);
   assign req_ready = (in_flight < FIFO_CW'(FIFO_DEPTH));
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // drive select decode of the control word low nibble
   assign nib = req_write_data[3:0];

   always_comb begin
      if (nib == 4'd0) begin
         sel_dec = NO_DRIVE;
      end else if (nib[0]) begin
         sel_dec = 3'd0;
      end else if (nib[1:0] == 2'd2) begin
         sel_dec = 3'd1;
      end else if (nib[2:0] == 3'd4) begin
         sel_dec = 3'd2;
      end else begin
         sel_dec = 3'd3;
      end
      sel_new = (sel_dec >= SEL_W'(DRIVES)) ? NO_DRIVE : sel_dec;
   end

   // drive whose state this beat touches, and the selection after it
   always_comb begin
      if (mode_type'(req_mode) == MODE_CTRL) begin
         drv_pick = sel_new;
         sel_in   = sel_new;
      end else begin
         drv_pick = sel_ff;
         sel_in   = sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= NO_DRIVE;
      end else if (req_fire) begin
         sel_ff <= sel_in;
      end
   end

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= mode_type'(req_mode);
         s1_dnum_ff  <= req_drive_number;
         s1_addr_ff  <= req_image_address;
         s1_wdata_ff <= req_write_data;
         s1_index_ff <= req_index_pulse;
         s1_drv_ff   <= drv_pick;
         s1_sel_ff   <= sel_in;
      end
   end

   fcss_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (drv_pick[DRV_ADDR_W-1:0]),
      .rd_data (st_cur),
      .wr_en   (st_wr),
      .wr_addr (drv_idx),
      .wr_data (st_next)
   );

   assign have     = (s1_drv_ff < SEL_W'(DRIVES));
   assign drv_idx  = s1_drv_ff[DRV_ADDR_W-1:0];
   assign present  = present_mask_ff[drv_idx];
   assign readonly = readonly_mask_ff[drv_idx];

   // stream position arithmetic
   always_comb begin
      unique case (st_cur.region)
         RGN_INDEX: posc = clamp_pos(st_cur.pos, IDX_LEN);
         RGN_DMARK: posc = clamp_pos(st_cur.pos, DATA_LEN);
         RGN_IMAGE: posc = clamp_pos(st_cur.pos, WPS_LEN);
         RGN_END:   posc = clamp_pos(st_cur.pos, END_LEN);
         default:   posc = st_cur.pos;
      endcase
      pos_inc    = posc + 9'd1;
      sector_inc = st_cur.sector + 4'd1;
      img_sum    = 13'(13'(st_cur.sector) * 13'(WORDS_PER_SECTOR)) + 13'(posc);
   end

   // state update and result word
   always_comb begin
      st_next = st_cur;
      st_wr   = 1'b0;
      word    = 16'd0;
      img_rd  = 1'b0;
      idle_in = idle_ff;
      if (s1_valid_ff) begin
         unique case (s1_mode_ff)
            MODE_CTRL: begin
               if (have && s1_wdata_ff[START_BIT] && !st_cur.active) begin
                  st_next        = DRV_STATE_RESET;
                  st_next.active = 1'b1;
                  st_wr          = 1'b1;
               end
            end
            MODE_STATUS: begin
               if (have) begin
                  if (s1_index_ff) begin
                     st_next        = DRV_STATE_RESET;
                     st_next.active = present;
                     st_wr          = 1'b1;
                  end
                  word = {s1_index_ff, 7'd0, st_next.active, 4'd0, readonly, present, 1'b1};
               end
            end
            MODE_DATA: begin
               if (have && st_cur.active) begin
                  st_wr = 1'b1;
                  if (st_cur.pend_trk) begin
                     st_next.pend_trk  = 1'b0;
                     st_next.pend_size = 1'b1;
                     word              = 16'd0;
                  end else if (st_cur.pend_size) begin
                     st_next.pend_size = 1'b0;
                     st_next.region    = RGN_DMARK;
                     st_next.pos       = '0;
                     word              = {3'd0, 5'({1'b0, st_cur.sector} + 5'd1), 8'h02};
                  end else begin
                     st_next.pos = pos_inc;
                     unique case (st_cur.region)
                        RGN_INDEX: begin
                           word = marker_word(posc, IDX_FILL, IDX_LEN, W_IDX);
                           if (pos_inc == IDX_LEN) begin
                              st_next.pend_trk = 1'b1;
                              st_next.pos      = '0;
                              st_next.region   = RGN_DMARK;
                           end
                        end
                        RGN_DMARK: begin
                           word = marker_word(posc, DATA_FILL, DATA_LEN, W_DATA);
                           if (pos_inc == DATA_LEN) begin
                              st_next.pos    = '0;
                              st_next.region = RGN_IMAGE;
                           end
                        end
                        RGN_IMAGE: begin
                           img_rd = present;
                           if (pos_inc == WPS_LEN) begin
                              st_next.pos    = '0;
                              st_next.region = RGN_END;
                           end
                        end
                        RGN_END: begin
                           word = marker_word(posc, END_FILL, END_LEN, W_END);
                           if (pos_inc == END_LEN) begin
                              st_next.sector = sector_inc;
                              st_next.pos    = '0;
                              st_next.region = RGN_INDEX;
                              if (sector_inc == SEC_W'(SECTORS_PER_TRACK)) begin
                                 st_next.active = 1'b0;
                              end
                           end
                        end
                        default: word = 16'd0;
                     endcase
                  end
               end else begin
                  idle_in = ~idle_ff;
                  word    = ~idle_ff;
               end
            end
            MODE_LOAD: begin
               word = 16'd0;
            end
            default: word = 16'd0;
         endcase
      end
   end

   // idle pattern register
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= IDLE_RESET;
      end else begin
         idle_ff <= idle_in;
      end
   end

   // image memory port: loads write, sector data reads
   assign img_wr   = s1_valid_ff && (s1_mode_ff == MODE_LOAD);
   assign img_addr = img_wr ? {s1_dnum_ff, s1_addr_ff} : {drv_idx, img_sum[IMG_ADDR_W-1:0]};

   fcss_image_ram u_image_ram (
      .clock   (clock),
      .wr_en   (img_wr),
      .rd_en   (img_rd),
      .addr    (img_addr),
      .wr_data (s1_wdata_ff),
      .rd_data (img_rdata)
   );

   // stage 2 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_img_ff  <= img_rd;
         s2_word_ff <= word;
         s2_sel_ff  <= s1_sel_ff;
      end
   end

   // result queue
   assign push_beat.read_data    = s2_img_ff ? img_rdata : s2_word_ff;
   assign push_beat.active_drive = s2_sel_ff;

   fcss_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (push_beat),
      .pop       (rsp_fire),
      .head_data (head_beat),
      .not_empty (rsp_valid),
      .count     (fifo_count)
   );

   assign rsp_read_data    = head_beat.read_data;
   assign rsp_active_drive = head_beat.active_drive;

   // checks
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight <= FIFO_CW'(FIFO_DEPTH))
      else $error("more beats in flight than queue slots");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request beat did not enter stage one");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active_drive <= NO_DRIVE))
      else $error("result carries an out of range drive number");

   a_img_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(img_wr && img_rd))
      else $error("image memory read and write in the same cycle");

endmodule

// ===== bench/tb_floppy_controller_sector_stream.sv =====
// self-checking bench for the floppy controller sector stream block
`timescale 1ns / 1ps

module tb_floppy_controller_sector_stream;
   import fcss_pkg::*;

   // mask register indexes on the csr port
   localparam logic REG_PRESENT  = 1'b0;
   localparam logic REG_READONLY = 1'b1;

   // model copies: the generator runs ahead as beats are queued, the checker follows accepted beats
   localparam int GEN = 0;
   localparam int CHK = 1;

   typedef struct {
      mode_type    mode;
      logic [1:0]  drive;
      logic [11:0] addr;
      logic [15:0] data;
      logic        index;
      bit          drain;
   } bus_access_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_mode = '0;
   logic [1:0]            req_drive_number = '0;
   logic [IMG_ADDR_W-1:0] req_image_address = '0;
   logic [15:0]           req_write_data = '0;
   logic                  req_index_pulse = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [15:0]           rsp_read_data;
   logic [SEL_W-1:0]      rsp_active_drive;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_index = 1'b0;
   logic [3:0]            csr_wr_data = '0;

   // controller state, one copy per model
   logic [3:0]    mask_present [2];
   logic [3:0]    mask_readonly [2];
   logic [2:0]    drive_sel [2];
   drv_state_type lane [2][4];
   logic [15:0]   idle_word [2];
   logic [15:0]   image_mem [2][IMG_MEM_DEPTH];
   bit            image_loaded [IMG_MEM_DEPTH];

   bus_access_type access_backlog[$];
   rsp_beat_type   awaited_results[$];
   int             req_count = 0;
   int             rsp_count = 0;
   int             queued = 0;
   int             mismatches = 0;
   int             send_gap = 0;
   int             send_burst = 0;
   int             recv_gap = 0;
   int             recv_burst = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;

   floppy_controller_sector_stream i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_drive_number  (req_drive_number),
      .req_image_address (req_image_address),
      .req_write_data    (req_write_data),
      .req_index_pulse   (req_index_pulse),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_active_drive  (rsp_active_drive),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [POS_W-1:0] bounded_pos(input logic [POS_W-1:0] pos,
                                                    input logic [POS_W-1:0] len);
      return (pos >= len) ? len - 9'd1 : pos;
   endfunction

   // fill words, then zeros, then the closing pair
   function automatic logic [15:0] frame_word(input logic [POS_W-1:0] p,
                                              input logic [POS_W-1:0] fills,
                                              input logic [POS_W-1:0] len,
                                              input logic [15:0] flag);
      if (p < fills) return W_FILL;
      if (p + 9'd2 < len) return 16'd0;
      if (p + 9'd2 == len) return W_LAST;
      return flag;
   endfunction

   function automatic logic [IMG_MEM_AW-1:0] image_index(input int d, input drv_state_type s);
      logic [POS_W-1:0] p;
      p = bounded_pos(s.pos, WPS_LEN);
      return {2'(d), 12'(s.sector * WORDS_PER_SECTOR + p)};
   endfunction

   function automatic void rewind_lane(input int m, input int d);
      lane[m][d].sector    = '0;
      lane[m][d].region    = RGN_INDEX;
      lane[m][d].pos       = '0;
      lane[m][d].pend_trk  = 1'b0;
      lane[m][d].pend_size = 1'b0;
   endfunction

   function automatic void clear_model(input int m);
      mask_present[m]  = '0;
      mask_readonly[m] = '0;
      drive_sel[m]     = NO_DRIVE;
      idle_word[m]     = IDLE_RESET;
      for (int d = 0; d < 4; d++) begin
         rewind_lane(m, d);
         lane[m][d].active = 1'b0;
      end
      for (int i = 0; i < IMG_MEM_DEPTH; i++) begin
         image_mem[m][i] = '0;
         if (m == GEN) image_loaded[i] = 1'b0;
      end
   endfunction

   // next word of the sector stream of an active drive
   function automatic logic [15:0] stream_word(input int m, input int d);
      drv_state_type    s;
      logic [15:0]      w;
      logic [POS_W-1:0] p;
      s = lane[m][d];
      w = 16'd0;
      if (s.pend_trk) begin
         s.pend_trk  = 1'b0;
         s.pend_size = 1'b1;
      end else if (s.pend_size) begin
         s.pend_size = 1'b0;
         s.region    = RGN_DMARK;
         s.pos       = '0;
         w = {8'(s.sector) + 8'd1, 8'd2};
      end else begin
         case (s.region)
            RGN_INDEX: begin
               p = bounded_pos(s.pos, IDX_LEN);
               w = frame_word(p, IDX_FILL, IDX_LEN, W_IDX);
               p = p + 9'd1;
               if (p == IDX_LEN) begin
                  s.pend_trk = 1'b1;
                  s.region   = RGN_DMARK;
                  p = '0;
               end
            end
            RGN_DMARK: begin
               p = bounded_pos(s.pos, DATA_LEN);
               w = frame_word(p, DATA_FILL, DATA_LEN, W_DATA);
               p = p + 9'd1;
               if (p == DATA_LEN) begin
                  s.region = RGN_IMAGE;
                  p = '0;
               end
            end
            RGN_IMAGE: begin
               p = bounded_pos(s.pos, WPS_LEN);
               // an absent image streams zeros
               if (mask_present[m][d]) w = image_mem[m][image_index(d, s)];
               p = p + 9'd1;
               if (p == WPS_LEN) begin
                  s.region = RGN_END;
                  p = '0;
               end
            end
            default: begin
               p = bounded_pos(s.pos, END_LEN);
               w = frame_word(p, END_FILL, END_LEN, W_END);
               p = p + 9'd1;
               if (p == END_LEN) begin
                  s.sector = s.sector + 4'd1;
                  if (s.sector == SECTORS_PER_TRACK) s.active = 1'b0;
                  s.region = RGN_INDEX;
                  p = '0;
               end
            end
         endcase
         s.pos = p;
      end
      lane[m][d] = s;
      return w;
   endfunction

   // one register access: updates model m and returns its result beat
   function automatic rsp_beat_type bus_access_result(input int m, input bus_access_type a);
      rsp_beat_type r;
      int           d;
      logic [3:0]   nib;
      logic [2:0]   pick;
      logic         present;
      r.read_data = 16'd0;
      d = int'(drive_sel[m]);
      case (a.mode)
         MODE_CTRL: begin
            // lowest set bit of the nibble picks the drive
            nib = a.data[3:0];
            if (nib == 4'd0) pick = NO_DRIVE;
            else if (nib[0]) pick = 3'd0;
            else if (nib[1]) pick = 3'd1;
            else if (nib[2]) pick = 3'd2;
            else pick = 3'd3;
            if (pick >= DRIVES) pick = NO_DRIVE;
            drive_sel[m] = pick;
            if (pick < NO_DRIVE && a.data[START_BIT] && !lane[m][pick].active) begin
               rewind_lane(m, pick);
               lane[m][pick].active = 1'b1;
            end
         end
         MODE_STATUS: begin
            if (d < DRIVES) begin
               present = mask_present[m][d];
               if (a.index) begin
                  rewind_lane(m, d);
                  lane[m][d].active = present;
               end
               r.read_data = {a.index, 7'd0, lane[m][d].active, 4'd0,
                              mask_readonly[m][d], present, 1'b1};
            end
         end
         MODE_DATA: begin
            if (d < DRIVES && lane[m][d].active) begin
               r.read_data = stream_word(m, d);
            end else begin
               idle_word[m] = ~idle_word[m];
               r.read_data  = idle_word[m];
            end
         end
         MODE_LOAD: begin
            image_mem[m][{a.drive, a.addr}] = a.data;
            if (m == GEN) image_loaded[{a.drive, a.addr}] = 1'b1;
         end
      endcase
      r.active_drive = drive_sel[m];
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // true when the next data read would fetch an image word never loaded
   function automatic bit load_needed(output logic [IMG_MEM_AW-1:0] where);
      int            d;
      drv_state_type s;
      where = '0;
      d = int'(drive_sel[GEN]);
      if (d >= DRIVES) return 1'b0;
      s = lane[GEN][d];
      if (!s.active || s.pend_trk || s.pend_size || s.region != RGN_IMAGE) return 1'b0;
      if (!mask_present[GEN][d]) return 1'b0;
      where = image_index(d, s);
      return !image_loaded[where];
   endfunction

   function automatic void queue_access(input mode_type mode, input logic [1:0] drive,
                                        input logic [11:0] addr, input logic [15:0] data,
                                        input logic index, input bit drain);
      bus_access_type        a;
      logic [IMG_MEM_AW-1:0] where;
      rsp_beat_type          ignored;
      if (mode == MODE_DATA && load_needed(where)) begin
         a.mode  = MODE_LOAD;
         a.drive = where[13:12];
         a.addr  = where[11:0];
         a.data  = 16'($urandom);
         a.index = 1'($urandom);
         a.drain = 1'b0;
         access_backlog.push_back(a);
         ignored = bus_access_result(GEN, a);
         queued++;
      end
      a.mode  = mode;
      a.drive = drive;
      a.addr  = addr;
      a.data  = data;
      a.index = index;
      a.drain = drain;
      access_backlog.push_back(a);
      ignored = bus_access_result(GEN, a);
      queued++;
   endfunction

   function automatic void queue_noisy(input mode_type mode, input logic index, input bit drain);
      queue_access(mode, 2'($urandom), 12'($urandom), 16'($urandom), index, drain);
   endfunction

   function automatic int next_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 23) == 0) burst = $urandom_range(10, 50);
      return $urandom_range(0, 19);
   endfunction

   task automatic wait_idle();
      while (access_backlog.size() != 0 || req_valid || req_count != rsp_count)
         @(negedge clock);
   endtask

   task automatic write_mask(input logic idx, input logic [3:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_PRESENT) mask_present[GEN] = value;
      else mask_readonly[GEN] = value;
   endtask

   // one random sequence; in half the draws a selected transfer with read bursts
   task automatic add_random_sequence();
      int         pick;
      int         len;
      logic [3:0] nib;
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
         nib = 4'($urandom_range(1, 15));
         queue_access(MODE_CTRL, 2'($urandom), 12'($urandom),
                      {7'($urandom), 1'b1, 4'($urandom), nib}, 1'($urandom),
                      $urandom_range(0, 19) == 0);
         if ($urandom_range(0, 2) == 0) queue_noisy(MODE_STATUS, 1'b1, 1'b0);
         len = $urandom_range(5, 80);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0)
               queue_noisy(MODE_STATUS, $urandom_range(0, 7) == 0, 1'b0);
            else
               queue_noisy(MODE_DATA, 1'($urandom), 1'b0);
         end
      end else if (pick == 5) begin
         repeat ($urandom_range(1, 6)) queue_noisy(MODE_LOAD, 1'($urandom), 1'b0);
      end else if (pick == 6) begin
         queue_noisy(MODE_CTRL, 1'($urandom), 1'b0);
      end else if (pick == 7) begin
         repeat ($urandom_range(1, 3)) queue_noisy(MODE_STATUS, 1'($urandom), 1'b0);
      end else if (pick == 8) begin
         repeat ($urandom_range(1, 8)) queue_noisy(MODE_DATA, 1'($urandom), 1'b0);
      end else begin
         queue_noisy(mode_type'($urandom_range(0, 3)), 1'($urandom), 1'b0);
      end
   endtask

   task automatic run_random_phase(input logic [3:0] present, input logic [3:0] readonly,
                                   input int target);
      int start;
      wait_idle();
      write_mask(REG_PRESENT, present);
      write_mask(REG_READONLY, readonly);
      @(negedge clock);
      start = queued;
      while (queued - start < target) add_random_sequence();
   endtask

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      clear_model(GEN);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_mask(REG_PRESENT, 4'b1010);
      write_mask(REG_READONLY, 4'b0110);
      @(negedge clock);

      // directed: idle pattern, decode, start rules, index rewind, extremes
      queue_access(MODE_DATA, 2'd0, 12'd0, 16'd0, 1'b0, 1'b0);
      queue_access(MODE_DATA, 2'd3, 12'hFFF, 16'hFFFF, 1'b1, 1'b0);
      queue_access(MODE_STATUS, 2'd0, 12'd0, 16'd0, 1'b1, 1'b0);
      queue_access(MODE_LOAD, 2'd3, 12'hFFF, 16'hFFFF, 1'b1, 1'b0);
      queue_access(MODE_LOAD, 2'd0, 12'd0, 16'd0, 1'b0, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h0100, 1'b0, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'hFEFF, 1'b0, 1'b0);
      queue_access(MODE_STATUS, 2'd0, 12'd0, 16'd0, 1'b0, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h010E, 1'b0, 1'b0);
      queue_access(MODE_STATUS, 2'd0, 12'd0, 16'd0, 1'b1, 1'b0);
      repeat (3) queue_access(MODE_DATA, 2'd0, 12'd0, 16'd0, 1'b0, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h010E, 1'b0, 1'b0);
      queue_access(MODE_DATA, 2'd0, 12'd0, 16'd0, 1'b0, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h000C, 1'b0, 1'b0);
      queue_access(MODE_DATA, 2'd0, 12'd0, 16'd0, 1'b0, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h0108, 1'b0, 1'b0);
      queue_access(MODE_STATUS, 2'd0, 12'd0, 16'd0, 1'b0, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h0004, 1'b0, 1'b0);
      queue_access(MODE_STATUS, 2'd0, 12'd0, 16'd0, 1'b1, 1'b0);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h0002, 1'b0, 1'b0);
      queue_access(MODE_DATA, 2'd0, 12'd0, 16'd0, 1'b0, 1'b1);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'hFFF0, 1'b0, 1'b0);
      queue_access(MODE_LOAD, 2'd2, 12'hAAA, 16'h5A5A, 1'b0, 1'b0);

      // a whole sector on an empty drive, then into the next one
      wait_idle();
      write_mask(REG_PRESENT, 4'h0);
      write_mask(REG_READONLY, 4'hF);
      @(negedge clock);
      queue_access(MODE_CTRL, 2'd0, 12'd0, 16'h0101, 1'b0, 1'b0);
      repeat (335) queue_noisy(MODE_DATA, 1'($urandom), 1'b0);
      queue_noisy(MODE_STATUS, 1'b0, 1'b0);

      run_random_phase(4'hF, 4'h0, 80);
      run_random_phase(4'($urandom), 4'($urandom), 70);

      wait_idle();
      repeat (10) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_results.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      bus_access_type nxt;
      logic           fire;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            req_count <= req_count + 1;
            send_gap = next_gap(send_burst);
         end
         if (!req_valid || fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (access_backlog.size() != 0 &&
                         (!access_backlog[0].drain || (!fire && req_count == rsp_count))) begin
               // a drain beat waits until every earlier result is back
               nxt = access_backlog.pop_front();
               req_valid         <= 1'b1;
               req_mode          <= nxt.mode;
               req_drive_number  <= nxt.drive;
               req_image_address <= nxt.addr;
               req_write_data    <= nxt.data;
               req_index_pulse   <= nxt.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      bus_access_type seen;
      rsp_beat_type   want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
         clear_model(CHK);
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_PRESENT) mask_present[CHK] = csr_wr_data;
            else mask_readonly[CHK] = csr_wr_data;
         end
         // expected result of each accepted request beat
         if (req_valid && req_ready) begin
            seen.mode  = mode_type'(req_mode);
            seen.drive = req_drive_number;
            seen.addr  = req_image_address;
            seen.data  = req_write_data;
            seen.index = req_index_pulse;
            seen.drain = 1'b0;
            awaited_results.push_back(bus_access_result(CHK, seen));
         end
         // compare each accepted result beat with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches < 40)
                  $display("%0t: unexpected result, expected none actual %h/%0d", $time,
                           rsp_read_data, rsp_active_drive);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  mismatches++;
                  if (mismatches < 40)
                     $display("%0t: read_data expected %h actual %h", $time,
                              want.read_data, rsp_read_data);
               end
               if (rsp_active_drive !== want.active_drive) begin
                  mismatches++;
                  if (mismatches < 40)
                     $display("%0t: active_drive expected %0d actual %0d", $time,
                              want.active_drive, rsp_active_drive);
               end
            end
            recv_gap = next_gap(recv_burst);
            // one long hold so the block backs up into its input
            if (!hold_done && rsp_count == 300) begin
               hold_left = 200;
               hold_done = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

endmodule
